// ----- design/vhbc_pkg.sv -----
// Shared types and constants for the voxel hidden-block cull unit.
package vhbc_pkg;

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_QUERY = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      CLS_AIR = 2'd0,
      CLS_POS = 2'd1,
      CLS_NEG = 2'd2
   } class_type;

   // Order in which a query visits the center voxel and its six face neighbors.
   typedef enum logic [2:0] {
      NB_CENTER = 3'd0,
      NB_UP     = 3'd1,
      NB_DOWN   = 3'd2,
      NB_LEFT   = 3'd3,
      NB_RIGHT  = 3'd4,
      NB_BACK   = 3'd5,
      NB_FRONT  = 3'd6
   } nbr_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_LAST,
      ST_EMIT
   } state_type;

   typedef logic [3:0]         coord_type;
   typedef logic [7:0]         height_type;
   typedef logic signed [15:0] value_type;

   typedef struct packed {
      logic rd;
      logic wr;
   } mem_ctl_type;

   typedef struct packed {
      logic valid;
      logic draw_flag;
   } result_type;

   function automatic class_type class_of(input value_type value);
      class_type cls;
      if (value[15]) begin
         cls = CLS_NEG;
      end else if (value != 16'sd0) begin
         cls = CLS_POS;
      end else begin
         cls = CLS_AIR;
      end
      return cls;
   endfunction

endpackage

// ----- design/vhbc_req_if.sv -----
// Request channel: one write or query beat per handshake.
interface vhbc_req_if;
   logic                  valid;
   logic                  ready;
   vhbc_pkg::op_type      operation;
   vhbc_pkg::coord_type   x_pos;
   vhbc_pkg::coord_type   z_pos;
   vhbc_pkg::height_type  y_pos;
   vhbc_pkg::value_type   block_value;

   modport source (output valid, output operation, output x_pos, output z_pos,
                   output y_pos, output block_value, input ready);
   modport sink   (input valid, input operation, input x_pos, input z_pos,
                   input y_pos, input block_value, output ready);
endinterface

// ----- design/vhbc_rsp_if.sv -----
// Response channel: one draw flag beat per query.
interface vhbc_rsp_if;
   logic valid;
   logic ready;
   logic draw_flag;

   modport source (output valid, output draw_flag, input ready);
   modport sink   (input valid, input draw_flag, output ready);
endinterface

// ----- design/vhbc_store.sv -----
// Single-port voxel class memory with registered read data.
module vhbc_store #(
   parameter int AW = 16
) (
   input  logic                  clock,
   input  vhbc_pkg::mem_ctl_type mem_ctl,
   input  logic [AW-1:0]         mem_addr,
   input  vhbc_pkg::class_type   mem_wdata,
   output vhbc_pkg::class_type   mem_rdata
);

   vhbc_pkg::class_type mem_ff [2**AW];
   vhbc_pkg::class_type rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_ctl.wr) begin
         mem_ff[mem_addr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_ctl.rd) begin
         rdata_ff <= mem_ff[mem_addr];
      end
   end

   assign mem_rdata = rdata_ff;

endmodule

// ----- design/vhbc_seq.sv -----
// Sequencer: clearing sweep, voxel writes and the seven-read neighbor walk of a query.
module vhbc_seq #(
   parameter int GRID_WIDTH  = 16,
   parameter int GRID_HEIGHT = 256,
   parameter int XW          = 4,
   parameter int YW          = 8,
   parameter int AW          = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  vhbc_pkg::op_type      operation,
   input  vhbc_pkg::coord_type   x_pos,
   input  vhbc_pkg::coord_type   z_pos,
   input  vhbc_pkg::height_type  y_pos,
   input  vhbc_pkg::value_type   block_value,
   input  logic                  rsp_busy,
   output vhbc_pkg::result_type  res,
   output vhbc_pkg::mem_ctl_type mem_ctl,
   output logic [AW-1:0]         mem_addr,
   output vhbc_pkg::class_type   mem_wdata,
   input  vhbc_pkg::class_type   mem_rdata
);

   vhbc_pkg::state_type state_ff, state_in;
   vhbc_pkg::nbr_type   step_ff, step_in;
   vhbc_pkg::nbr_type   rd_step_ff;
   logic                rd_pend_ff;
   logic [AW-1:0]       clr_ff, clr_in;
   logic [XW-1:0]       x_ff, z_ff, nx, nz;
   logic [YW-1:0]       y_ff, ny;
   logic                drawn_ff, drawn_in;
   logic                accept, in_grid, border, rd_bad, clr_done;
   logic [7:0]          opnd, sum;
   logic                dec;

   assign accept = in_valid && in_ready;

   assign in_grid = ({1'b0, x_pos} < 5'(GRID_WIDTH)) &&
                    ({1'b0, z_pos} < 5'(GRID_WIDTH)) &&
                    ({1'b0, y_pos} < 9'(GRID_HEIGHT));
   assign border = (x_pos == 4'd0) || (x_pos == 4'(GRID_WIDTH - 1)) ||
                   (z_pos == 4'd0) || (z_pos == 4'(GRID_WIDTH - 1)) ||
                   (y_pos == 8'd0) || (y_pos == 8'(GRID_HEIGHT - 1));

   assign clr_done = &clr_ff;

   // Shared step unit: one coordinate is moved by one per neighbor read.
   always_comb begin
      opnd = 8'(y_ff);
      dec  = 1'b0;
      case (step_ff)
         vhbc_pkg::NB_UP:    begin opnd = 8'(y_ff); dec = 1'b0; end
         vhbc_pkg::NB_DOWN:  begin opnd = 8'(y_ff); dec = 1'b1; end
         vhbc_pkg::NB_LEFT:  begin opnd = 8'(x_ff); dec = 1'b1; end
         vhbc_pkg::NB_RIGHT: begin opnd = 8'(x_ff); dec = 1'b0; end
         vhbc_pkg::NB_BACK:  begin opnd = 8'(z_ff); dec = 1'b1; end
         vhbc_pkg::NB_FRONT: begin opnd = 8'(z_ff); dec = 1'b0; end
         default:            begin opnd = 8'(y_ff); dec = 1'b0; end
      endcase
      sum = opnd + (dec ? 8'hFF : 8'h01);
   end

   always_comb begin
      nx = x_ff;
      ny = y_ff;
      nz = z_ff;
      case (step_ff)
         vhbc_pkg::NB_UP,   vhbc_pkg::NB_DOWN:  ny = sum[YW-1:0];
         vhbc_pkg::NB_LEFT, vhbc_pkg::NB_RIGHT: nx = sum[XW-1:0];
         vhbc_pkg::NB_BACK, vhbc_pkg::NB_FRONT: nz = sum[XW-1:0];
         default: ;
      endcase
   end

   // The center voxel hides only if it is not negative; a neighbor hides it only if positive.
   assign rd_bad = (rd_step_ff == vhbc_pkg::NB_CENTER) ? (mem_rdata == vhbc_pkg::CLS_NEG)
                                                        : (mem_rdata != vhbc_pkg::CLS_POS);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         vhbc_pkg::ST_CLEAR: begin
            if (clr_done) state_in = vhbc_pkg::ST_IDLE;
         end
         vhbc_pkg::ST_IDLE: begin
            if (accept && operation == vhbc_pkg::OP_QUERY) begin
               state_in = (!in_grid || border) ? vhbc_pkg::ST_EMIT : vhbc_pkg::ST_READ;
            end
         end
         vhbc_pkg::ST_READ: begin
            if (step_ff == vhbc_pkg::NB_FRONT) state_in = vhbc_pkg::ST_LAST;
         end
         vhbc_pkg::ST_LAST: state_in = vhbc_pkg::ST_EMIT;
         vhbc_pkg::ST_EMIT: begin
            if (!rsp_busy) state_in = vhbc_pkg::ST_IDLE;
         end
         default: state_in = vhbc_pkg::ST_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      in_ready      = 1'b0;
      mem_ctl       = '0;
      mem_addr      = {ny, nz, nx};
      mem_wdata     = vhbc_pkg::class_of(block_value);
      res.valid     = 1'b0;
      res.draw_flag = drawn_ff;
      case (state_ff)
         vhbc_pkg::ST_CLEAR: begin
            mem_ctl.wr = 1'b1;
            mem_addr   = clr_ff;
            mem_wdata  = vhbc_pkg::CLS_AIR;
         end
         vhbc_pkg::ST_IDLE: begin
            in_ready   = 1'b1;
            mem_addr   = {y_pos[YW-1:0], z_pos[XW-1:0], x_pos[XW-1:0]};
            mem_ctl.wr = in_valid && operation == vhbc_pkg::OP_WRITE && in_grid;
         end
         vhbc_pkg::ST_READ: mem_ctl.rd = 1'b1;
         vhbc_pkg::ST_EMIT: res.valid = !rsp_busy;
         default: ;
      endcase
   end

   always_comb begin
      clr_in   = (state_ff == vhbc_pkg::ST_CLEAR) ? clr_ff + 1'b1 : clr_ff;
      step_in  = step_ff;
      drawn_in = drawn_ff;
      if (accept) begin
         step_in  = vhbc_pkg::NB_CENTER;
         drawn_in = !in_grid || border;
      end else begin
         if (state_ff == vhbc_pkg::ST_READ && step_ff != vhbc_pkg::NB_FRONT) begin
            step_in = vhbc_pkg::nbr_type'(step_ff + 3'd1);
         end
         if (rd_pend_ff && rd_bad) drawn_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= vhbc_pkg::ST_CLEAR;
         clr_ff     <= '0;
         rd_pend_ff <= 1'b0;
         step_ff    <= vhbc_pkg::NB_CENTER;
      end else begin
         state_ff   <= state_in;
         clr_ff     <= clr_in;
         rd_pend_ff <= mem_ctl.rd;
         step_ff    <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_step_ff <= step_ff;
      drawn_ff   <= drawn_in;
      if (accept) begin
         x_ff <= x_pos[XW-1:0];
         z_ff <= z_pos[XW-1:0];
         y_ff <= y_pos[YW-1:0];
      end
   end

`ifndef NO_ASSERTIONS
   a_no_accept_during_read: assert property (@(posedge clock) disable iff (reset)
      rd_pend_ff |-> !in_ready)
      else $error("request taken while a store read was outstanding");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      res.valid |-> !rsp_busy)
      else $error("result issued while the response register was still full");
   a_walk_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == vhbc_pkg::ST_READ && step_ff == vhbc_pkg::NB_FRONT)
      |=> (state_ff == vhbc_pkg::ST_LAST && rd_pend_ff))
      else $error("neighbor walk did not finish after the last read");
   a_single_port: assert property (@(posedge clock) disable iff (reset)
      !(mem_ctl.wr && mem_ctl.rd))
      else $error("store read and write in the same cycle");
   a_border_fast: assert property (@(posedge clock) disable iff (reset)
      (accept && operation == vhbc_pkg::OP_QUERY && border)
      |=> (state_ff == vhbc_pkg::ST_EMIT && drawn_ff))
      else $error("border query did not go straight to a drawn result");
`endif

endmodule

// ----- design/voxel_hidden_block_cull_unit.sv -----
// Timing: a write beat is stored when accepted; a border or out-of-grid query goes
// straight to the emit state, an interior query first through its store reads.
// Throughput: one write per cycle while no query is in progress; a query holds off new
// requests until its result is issued; its seven reads (center and six neighbors) share
// the single store port. Reset: synchronous; a clearing sweep writes air to all 2**AW
// store addresses (65536 at default size) while req_ch.ready stays low.
module voxel_hidden_block_cull_unit #(
   parameter int GRID_WIDTH  = 16,
   parameter int GRID_HEIGHT = 256
) (
   input  logic         clock,
   input  logic         reset,
   vhbc_req_if.sink     req_ch,
   vhbc_rsp_if.source   rsp_ch
);

   localparam int XW = $clog2(GRID_WIDTH);
   localparam int YW = $clog2(GRID_HEIGHT);
   localparam int AW = YW + 2 * XW;

   vhbc_pkg::mem_ctl_type mem_ctl;
   logic [AW-1:0]         mem_addr;
   vhbc_pkg::class_type   mem_wdata, mem_rdata;
   vhbc_pkg::result_type  res;
   logic                  rsp_busy;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_flag_ff, rsp_flag_in;

   assign rsp_busy = rsp_valid_ff && !rsp_ch.ready;

   vhbc_seq #(
      .GRID_WIDTH  (GRID_WIDTH),
      .GRID_HEIGHT (GRID_HEIGHT),
      .XW          (XW),
      .YW          (YW),
      .AW          (AW)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_ch.valid),
      .in_ready    (req_ch.ready),
      .operation   (req_ch.operation),
      .x_pos       (req_ch.x_pos),
      .z_pos       (req_ch.z_pos),
      .y_pos       (req_ch.y_pos),
      .block_value (req_ch.block_value),
      .rsp_busy    (rsp_busy),
      .res         (res),
      .mem_ctl     (mem_ctl),
      .mem_addr    (mem_addr),
      .mem_wdata   (mem_wdata),
      .mem_rdata   (mem_rdata)
   );

   vhbc_store #(
      .AW (AW)
   ) u_store (
      .clock     (clock),
      .mem_ctl   (mem_ctl),
      .mem_addr  (mem_addr),
      .mem_wdata (mem_wdata),
      .mem_rdata (mem_rdata)
   );

   // Output register: holds the response beat until the sink takes it.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_flag_in  = rsp_flag_ff;
      if (res.valid) begin
         rsp_valid_in = 1'b1;
         rsp_flag_in  = res.draw_flag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_flag_ff <= rsp_flag_in;
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.draw_flag = rsp_flag_ff;

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the voxel hidden-block cull unit.
module tb_top;

   localparam int GRID_W      = 16;
   localparam int GRID_H      = 256;
   localparam int RANDOM_BEATS = 1050;
   localparam int CALM_BEATS   = 900;
   localparam int DRAIN_CYCLES = 16;
   localparam int CYCLE_LIMIT  = 500000;

   // Tracks the sign class of every voxel and the draw flags still owed by the block.
   class draw_flag_tracker;
      vhbc_pkg::class_type voxel_classes[GRID_W*GRID_W*GRID_H];
      bit        expected_flags[$];
      int        errors;
      int        flags_checked;
      int        enclosed_seen;
      int        writes_seen;

      function new();
         foreach (voxel_classes[i]) voxel_classes[i] = vhbc_pkg::CLS_AIR;
         errors        = 0;
         flags_checked = 0;
         enclosed_seen = 0;
         writes_seen   = 0;
      endfunction

      function int cell_index(input int x, input int z, input int y);
         return (y * GRID_W + z) * GRID_W + x;
      endfunction

      function bit is_solid(input int x, input int z, input int y);
         return voxel_classes[cell_index(x, z, y)] == vhbc_pkg::CLS_POS;
      endfunction

      function bit draw_flag_for(input int x, input int z, input int y);
         if (x == 0 || x >= GRID_W - 1 || z == 0 || z >= GRID_W - 1 ||
             y == 0 || y >= GRID_H - 1) begin
            return 1'b1;
         end
         if (voxel_classes[cell_index(x, z, y)] == vhbc_pkg::CLS_NEG) return 1'b1;
         // All six face neighbors must be strictly positive to hide the voxel.
         return !(is_solid(x, z, y + 1) && is_solid(x, z, y - 1) &&
                  is_solid(x - 1, z, y) && is_solid(x + 1, z, y) &&
                  is_solid(x, z - 1, y) && is_solid(x, z + 1, y));
      endfunction

      function void accept_request(input vhbc_pkg::op_type op,
                                   input vhbc_pkg::coord_type x,
                                   input vhbc_pkg::coord_type z,
                                   input vhbc_pkg::height_type y,
                                   input vhbc_pkg::value_type v);
         vhbc_pkg::class_type cls;
         if (op == vhbc_pkg::OP_WRITE) begin
            if (v < 0) begin
               cls = vhbc_pkg::CLS_NEG;
            end else if (v != 0) begin
               cls = vhbc_pkg::CLS_POS;
            end else begin
               cls = vhbc_pkg::CLS_AIR;
            end
            voxel_classes[cell_index(x, z, y)] = cls;
            writes_seen++;
         end else begin
            expected_flags.push_back(draw_flag_for(x, z, y));
         end
      endfunction

      function void check_draw_flag(input logic actual);
         bit want;
         if (expected_flags.size() == 0) begin
            $display("%0t: unexpected draw flag beat, actual %b", $time, actual);
            errors++;
            return;
         end
         want = expected_flags.pop_front();
         flags_checked++;
         if (want == 1'b0) enclosed_seen++;
         if (actual !== want) begin
            $display("%0t: draw_flag mismatch, expected %b actual %b", $time, want, actual);
            errors++;
         end
      endfunction

      function int pending();
         return expected_flags.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   int   idle_pct;
   int   beats_sent;

   vhbc_req_if req_ch ();
   vhbc_rsp_if rsp_ch ();

   draw_flag_tracker tracker = new();

   voxel_hidden_block_cull_unit DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("Timed out after %0d cycles", CYCLE_LIMIT);
      $display("FAIL voxel_hidden_block_cull_unit");
      $finish;
   end

   // Result side: ready drops in bursts of random length while idling is enabled.
   initial begin
      int stall;
      stall = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall > 0) begin
            stall--;
            rsp_ch.ready <= 1'b0;
         end else if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            stall = $urandom_range(0, 6);
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         tracker.check_draw_flag(rsp_ch.draw_flag);
      end
   end

   task automatic send_request(input vhbc_pkg::op_type op, input vhbc_pkg::coord_type x,
                               input vhbc_pkg::coord_type z, input vhbc_pkg::height_type y,
                               input vhbc_pkg::value_type v);
      int gap;
      req_ch.valid       <= 1'b1;
      req_ch.operation   <= op;
      req_ch.x_pos       <= x;
      req_ch.z_pos       <= z;
      req_ch.y_pos       <= y;
      req_ch.block_value <= v;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      tracker.accept_request(op, x, z, y, v);
      beats_sent++;
      if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         gap = $urandom_range(1, 7);
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic write_voxel(input int x, input int z, input int y,
                              input vhbc_pkg::value_type v);
      send_request(vhbc_pkg::OP_WRITE, vhbc_pkg::coord_type'(x), vhbc_pkg::coord_type'(z),
                   vhbc_pkg::height_type'(y), v);
   endtask

   task automatic query_voxel(input int x, input int z, input int y);
      send_request(vhbc_pkg::OP_QUERY, vhbc_pkg::coord_type'(x), vhbc_pkg::coord_type'(z),
                   vhbc_pkg::height_type'(y), vhbc_pkg::value_type'($urandom));
   endtask

   function automatic vhbc_pkg::value_type value_of_class(input vhbc_pkg::class_type cls);
      vhbc_pkg::value_type v;
      case (cls)
         vhbc_pkg::CLS_POS: v = vhbc_pkg::value_type'($urandom_range(1, 32767));
         vhbc_pkg::CLS_NEG: v = vhbc_pkg::value_type'(-$urandom_range(1, 32768));
         default: v = '0;
      endcase
      return v;
   endfunction

   // Writes the six face neighbors of a random voxel (usually all solid), then usually its center,
   // then queries it, so that enclosed voxels come up often.
   task automatic build_enclosure();
      int        cx, cz, cy, nx, nz, ny, broken, pick;
      vhbc_pkg::class_type bad_cls;
      cx = $urandom_range(1, GRID_W - 2);
      cz = $urandom_range(1, GRID_W - 2);
      pick = $urandom_range(99);
      if (pick < 40) begin
         cy = $urandom_range(120, 127);
      end else if (pick < 50) begin
         cy = ($urandom_range(1) == 0) ? 1 : GRID_H - 2;
      end else begin
         cy = $urandom_range(1, GRID_H - 2);
      end
      broken = ($urandom_range(99) < 25) ? $urandom_range(0, 5) : -1;
      bad_cls = ($urandom_range(1) == 0) ? vhbc_pkg::CLS_AIR : vhbc_pkg::CLS_NEG;
      for (int n = 0; n < 6; n++) begin
         nx = cx;
         nz = cz;
         ny = cy;
         case (n)
            0: ny = cy + 1;
            1: ny = cy - 1;
            2: nx = cx - 1;
            3: nx = cx + 1;
            4: nz = cz - 1;
            default: nz = cz + 1;
         endcase
         write_voxel(nx, nz, ny, (n == broken) ? value_of_class(bad_cls)
                                               : value_of_class(vhbc_pkg::CLS_POS));
      end
      if ($urandom_range(99) < 70) begin
         write_voxel(cx, cz, cy,
                     value_of_class(vhbc_pkg::class_type'($urandom_range(0, 2))));
      end
      query_voxel(cx, cz, cy);
      if ($urandom_range(99) < 30) begin
         query_voxel(cx + $urandom_range(0, 2) - 1, cz + $urandom_range(0, 2) - 1,
                     cy + $urandom_range(0, 2) - 1);
      end
   endtask

   task automatic send_noise();
      send_request(vhbc_pkg::op_type'($urandom_range(1)), vhbc_pkg::coord_type'($urandom),
                   vhbc_pkg::coord_type'($urandom), vhbc_pkg::height_type'($urandom),
                   vhbc_pkg::value_type'($urandom));
   endtask

   initial begin
      int random_start;
      int next_mode;
      reset              <= 1'b1;
      req_ch.valid       <= 1'b0;
      req_ch.operation   <= vhbc_pkg::OP_WRITE;
      req_ch.x_pos       <= '0;
      req_ch.z_pos       <= '0;
      req_ch.y_pos       <= '0;
      req_ch.block_value <= '0;
      idle_pct   = 0;
      beats_sent = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: grid corners and border, then an enclosure around (7,7,100).
      idle_pct = 20;
      query_voxel(0, 0, 0);
      query_voxel(GRID_W - 1, GRID_W - 1, GRID_H - 1);
      write_voxel(0, GRID_W - 1, 128, 16'sh7fff);
      query_voxel(0, GRID_W - 1, 128);
      query_voxel(8, 8, 128);
      write_voxel(7, 7, 101, 16'sd1);
      write_voxel(7, 7, 99, 16'sd32767);
      write_voxel(6, 7, 100, 16'sh1234);
      write_voxel(8, 7, 100, 16'sd2);
      write_voxel(7, 6, 100, 16'sh4000);
      write_voxel(7, 8, 100, 16'sh0100);
      query_voxel(7, 7, 100);
      write_voxel(7, 7, 100, -16'sd32768);
      query_voxel(7, 7, 100);
      write_voxel(7, 7, 100, 16'sd5);
      query_voxel(7, 7, 100);
      // A negative neighbor must not count as solid.
      write_voxel(6, 7, 100, -16'sd1);
      query_voxel(7, 7, 100);
      write_voxel(6, 7, 100, 16'sd3);
      write_voxel(7, 8, 100, 16'sd0);
      query_voxel(7, 7, 100);

      random_start = beats_sent;
      next_mode    = 0;
      while (beats_sent - random_start < RANDOM_BEATS) begin
         if (beats_sent - random_start >= CALM_BEATS) begin
            idle_pct = 0;
         end else if (beats_sent - random_start >= next_mode) begin
            case ($urandom_range(2))
               0: idle_pct = 0;
               1: idle_pct = 15;
               default: idle_pct = 40;
            endcase
            next_mode = beats_sent - random_start + $urandom_range(60, 140);
         end
         if ($urandom_range(99) < 80) begin
            build_enclosure();
         end else begin
            send_noise();
         end
      end
      req_ch.valid <= 1'b0;

      while (tracker.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d beats: %0d voxel writes, %0d draw flags checked, %0d of them enclosed.",
               beats_sent, tracker.writes_seen, tracker.flags_checked, tracker.enclosed_seen);
      if (tracker.errors == 0) begin
         $display("PASS voxel_hidden_block_cull_unit");
      end else begin
         $display("FAIL voxel_hidden_block_cull_unit");
      end
      $finish;
   end

endmodule
